/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/utt_pkg.sv */
// Package with the types and constants of the UTF-8 to UTF-16 decoder.
package utt_pkg;

    localparam logic [15:0] UNIT_ERR      = 16'h003F;
    localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
    localparam logic [20:0] CODE_MAX      = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;
    localparam logic [7:0]  ASCII_MAX     = 8'h7F;
    localparam logic [7:0]  CONT_MAX      = 8'hBF;
    localparam logic [7:0]  LEAD2_MAX     = 8'hDF;
    localparam logic [7:0]  LEAD3_MAX     = 8'hEF;
    localparam logic [7:0]  LEAD4_MAX     = 8'hF7;
    localparam int          QUEUE_DEPTH   = 4;

    // Kind of an incoming byte.
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_byte_class;

    // One queued piece of work: one or two code units and the end-of-string mark.
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        two;
        logic        eos;
    } t_entry;

endpackage

/* hdl/utt_byte_if.sv */
// Stream interface that carries one UTF-8 byte per beat.
interface utt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

/* hdl/utt_unit_if.sv */
// Stream interface that carries one UTF-16 code unit per beat.
interface utt_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_last;

    modport source (output valid, output code_unit, output run_last, output string_last,
                    input ready);
    modport sink (input valid, input code_unit, input run_last, input string_last,
                  output ready);
endinterface

/* hdl/utt_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds queue entries.
module utt_front
    import utt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    utt_byte_if.sink       i_byte,
    input  logic           i_full,
    output logic           o_push,
    output t_entry         o_entry
);

    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_accum, n_accum;
    logic [20:0] accum_shift;
    logic [19:0] supp_off;
    logic [1:0]  pend_dec;
    logic [1:0]  unit_cnt;
    logic        accept;
    t_byte_class cls;
    t_entry      entry;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    always_comb begin
        priority if (i_byte.in_byte <= ASCII_MAX) begin
            cls = CLS_ASCII;
        end else if (i_byte.in_byte <= CONT_MAX) begin
            cls = CLS_CONT;
        end else if (i_byte.in_byte <= LEAD2_MAX) begin
            cls = CLS_LEAD2;
        end else if (i_byte.in_byte <= LEAD3_MAX) begin
            cls = CLS_LEAD3;
        end else if (i_byte.in_byte <= LEAD4_MAX) begin
            cls = CLS_LEAD4;
        end else begin
            cls = CLS_BAD;
        end
    end

    assign accum_shift = {r_accum[14:0], i_byte.in_byte[5:0]};
    assign supp_off    = 20'(accum_shift - SUPP_BASE);
    assign pend_dec    = r_pending - 2'd1;

    always_comb begin
        n_pending   = r_pending;
        n_accum     = r_accum;
        unit_cnt    = 2'd0;
        entry.unit0 = UNIT_ERR;
        entry.unit1 = UNIT_ERR;
        entry.eos   = i_byte.end_of_string;
        unique case (cls)
            CLS_ASCII: begin
                n_pending = 2'd0;
                if (r_pending != 2'd0) begin
                    entry.unit1 = {8'h00, i_byte.in_byte};
                    unit_cnt    = 2'd2;
                end else begin
                    entry.unit0 = {8'h00, i_byte.in_byte};
                    unit_cnt    = 2'd1;
                end
            end
            CLS_CONT: begin
                if (r_pending != 2'd0) begin
                    n_accum   = accum_shift;
                    n_pending = pend_dec;
                    if (pend_dec == 2'd0) begin
                        if (accum_shift <= BMP_MAX) begin
                            entry.unit0 = accum_shift[15:0];
                            unit_cnt    = 2'd1;
                        end else if (accum_shift <= CODE_MAX) begin
                            // Both surrogate bases have their low ten bits clear.
                            entry.unit0 = HIGH_SURR | {6'd0, supp_off[19:10]};
                            entry.unit1 = LOW_SURR | {6'd0, supp_off[9:0]};
                            unit_cnt    = 2'd2;
                        end else begin
                            unit_cnt = 2'd1;
                        end
                    end
                end else begin
                    unit_cnt = 2'd1;
                end
            end
            CLS_LEAD2: begin
                n_pending = 2'd1;
                n_accum   = {16'd0, i_byte.in_byte[4:0]};
            end
            CLS_LEAD3: begin
                n_pending = 2'd2;
                n_accum   = {17'd0, i_byte.in_byte[3:0]};
            end
            CLS_LEAD4: begin
                n_pending = 2'd3;
                n_accum   = {18'd0, i_byte.in_byte[2:0]};
            end
            default: begin
                n_pending = 2'd0;
                unit_cnt  = 2'd1;
            end
        endcase
        if (i_byte.end_of_string) begin
            // A sequence still open here has produced nothing yet.
            if (n_pending != 2'd0) begin
                entry.unit0 = UNIT_ERR;
                unit_cnt    = 2'd1;
            end
            n_pending = 2'd0;
            n_accum   = 21'd0;
        end
        entry.two = (unit_cnt == 2'd2);
    end

    assign o_push  = accept && (unit_cnt != 2'd0);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_accum   <= 21'd0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule

/* hdl/utt_queue.sv */
// Small register queue of work entries between the front and back ends.
module utt_queue
    import utt_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(P_DEPTH);

    t_entry          r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/utt_back.sv */
// Back end: sends the code units of the head entry through an output register.
module utt_back
    import utt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    utt_unit_if.source o_unit
);

    logic        r_valid;
    logic        r_sub, n_sub;
    logic [15:0] r_code;
    logic        r_run_last;
    logic        r_string_last;
    logic        load, take, last;

    assign load  = !r_valid || o_unit.ready;
    assign take  = load && !i_empty;
    assign last  = r_sub || !i_head.two;
    assign o_pop = take && last;
    assign n_sub = take ? !last : r_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            r_sub <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code        <= r_sub ? i_head.unit1 : i_head.unit0;
            r_run_last    <= last;
            r_string_last <= last && i_head.eos;
        end
    end

    assign o_unit.valid       = r_valid;
    assign o_unit.code_unit   = r_code;
    assign o_unit.run_last    = r_run_last;
    assign o_unit.string_last = r_string_last;

endmodule

/* hdl/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16 decoder.
//
// The block takes one UTF-8 byte per beat on i_byte, each with an end-of-string
// mark, and sends UTF-16 code units on o_unit, one per beat. A byte gives no
// unit (a lead byte or an inner continuation byte), one unit, or two (a
// surrogate pair, or the error unit '?' followed by an ASCII byte that broke
// off a sequence). run_last marks the last unit of a byte and string_last the
// last unit of a string; every byte marked end-of-string gives at least one.
// The front end accepts one byte every cycle while the queue is not full and
// classifies it; the back end drains a four-entry queue through an output
// register, one unit a cycle while the receiver is ready. A unit goes through
// the queue, then the output register, to o_unit. The sustained rate is one byte
// a cycle while bytes give at most one unit; a two-unit byte takes a beat per
// unit at the output, and the queue absorbs that. When the receiver stalls, the
// output register holds its beat; i_byte.ready falls once the queue fills.
// A synchronous reset clears the open sequence, the queue and the output valid.
module utf8_to_utf16_decoder
    import utt_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utt_byte_if.sink   i_byte,
    utt_unit_if.source o_unit
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push, pop, q_empty, q_full;

    // The front end keeps the decoding state and forms whole entries.
    utt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // The queue lets the front keep taking bytes while the back end waits.
    utt_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end pops an entry once its last unit has gone into the output register.
    utt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_unit  (o_unit)
    );

endmodule

/* hdl/utt_checker.sv */
// Port-level checker for the decoder, bound to its top level.
`include "assert_macros.svh"

module utt_checker
    import utt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_code_unit,
    input logic        i_run_last,
    input logic        i_string_last
);

    logic        out_beat;
    logic        high_surr;
    logic        str_end;
    logic        open_run;
    logic        open_ok;
    logic        open_beat;
    logic        stall;
    logic [18:0] beat_bits;

    assign out_beat  = i_out_valid && i_out_ready;
    assign high_surr = (i_code_unit[15:10] == 6'b110110);
    assign str_end   = i_out_valid && i_string_last;
    assign open_run  = i_out_valid && !i_run_last;
    // Only the first unit of a surrogate pair or the error unit ahead of an ASCII
    // byte can leave a run open.
    assign open_ok   = high_surr || (i_code_unit == UNIT_ERR);
    assign open_beat = out_beat && !i_run_last;
    assign stall     = i_out_valid && !i_out_ready;
    assign beat_bits = {i_out_valid, i_code_unit, i_run_last, i_string_last};

    `ASSERT_IMPLY(a_str_last_run, i_clk, i_rst_n, str_end, i_run_last, "string_last mid run")
    `ASSERT_IMPLY(a_open_run_unit, i_clk, i_rst_n, open_run, open_ok, "bad unit before run end")
    `ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, open_beat, i_out_valid, "gap inside a run")
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stall, $stable(beat_bits), "stall changed beat")

endmodule

bind utf8_to_utf16_decoder utt_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_unit.valid),
    .i_out_ready   (o_unit.ready),
    .i_code_unit   (o_unit.code_unit),
    .i_run_last    (o_unit.run_last),
    .i_string_last (o_unit.string_last)
);
